[hdl/gzc_pkg.sv]
// shared types and constants for the gyro zero calibration filter
`default_nettype none
package gzc_pkg;

  // width of the divider dividend and quotient
  localparam int DIV_N = 20;

  // configuration register indexes
  localparam logic [1:0] REG_AVERAGE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_AVERAGE_ENABLE  = 2'd1;
  localparam logic [1:0] REG_FAILSAFE_ENABLE = 2'd2;
  localparam logic [1:0] REG_TILT_MODE       = 2'd3;

  // tilt mode codes
  localparam logic [1:0] TILT_NONE  = 2'd0;
  localparam logic [1:0] TILT_LEFT  = 2'd1;
  localparam logic [1:0] TILT_RIGHT = 2'd2;

  // calibration constants
  localparam logic [9:0] CAL_LOAD     = 10'd512;
  localparam logic [9:0] CAL_RESTART  = 10'd1000;
  localparam logic [9:0] CAL_LAST     = 10'd1;
  localparam logic [9:0] CHECK_PERIOD = 10'd10;
  localparam int         OFFSET_SHIFT = 9;

  // reciprocal of the check period, exact for counts up to 1028
  localparam logic [7:0] CHECK_RECIP       = 8'd205;
  localparam int         CHECK_RECIP_SHIFT = 11;

  localparam logic signed [16:0] MOTION_LIMIT = 17'sd8;
  localparam logic signed [16:0] GLITCH_LIMIT = 17'sd800;

  // rotation scale 7/10
  localparam logic signed [19:0] TILT_NUM = 20'sd7;
  localparam logic [3:0]         TILT_DEN = 4'd10;

  // reciprocal of the rotation divisor, exact below 2**22
  localparam logic [19:0] TILT_RECIP       = 20'd838861;
  localparam int          TILT_RECIP_SHIFT = 23;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

[hdl/gzc_div.sv]
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module gzc_div #(
  parameter int DVS_W = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gzc_pkg::DIV_N-1:0]  dividend,
  input  logic [DVS_W-1:0]           divisor,
  output gzc_pkg::div_stat_t         stat,
  output logic [gzc_pkg::DIV_N-1:0]  quotient,
  output logic [DVS_W-1:0]           remainder
);
  import gzc_pkg::*;

  localparam int STEP_W = $clog2(DIV_N + 1);

  logic [DIV_N-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [STEP_W-1:0] steps;
  logic busy;
  logic done;
  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic fits;

  always_comb begin
    trial = {rem, quo[DIV_N-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && !start && (steps == STEP_W'(1));
      if (start) begin
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
        steps <= STEP_W'(DIV_N);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo   <= {quo[DIV_N-2:0], fits};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.done = done;

endmodule
`default_nettype wire

[hdl/gyro_zero_calibrate_filter.sv]
// top level of the gyro zero calibration and conditioning filter
`default_nettype none
// Takes one three-axis gyro sample per item and returns one result item. A single
// 20-step restoring divider is shared by the ring index update and the three moving
// average divisions, one axis at a time. The tenth-count motion check and the 7/10
// rotation use reciprocal multiplication instead. From one acceptance until the item
// is finished, the input is stalled. A finished result waits in an output register, so
// the next item is taken while it is held; a result still held when the next one is
// ready holds that item in its finish state and keeps the input stalled.
// The averaging ring is a memory of AVERAGE_DEPTH rows with one valid bit per row,
// so no clearing pass is needed after reset.
module gyro_zero_calibrate_filter #(
  parameter int AVERAGE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [4:0]         wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               begin_calibration,
  input  logic signed [13:0] raw_x,
  input  logic signed [13:0] raw_y,
  input  logic signed [13:0] raw_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] rate_x,
  output logic signed [15:0] rate_y,
  output logic signed [15:0] rate_z,
  output logic               calibrating,
  output logic               calibration_done,
  output logic               motion_restart
);
  import gzc_pkg::*;

  localparam int LEN_W = $clog2(AVERAGE_DEPTH + 1);
  localparam int DVS_W = (LEN_W > 4) ? LEN_W : 4;
  localparam int POS_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CAL_CHK, S_CAL_AXIS, S_CAL_END, S_POS, S_RD_POS, S_RD_WAIT, S_CLAMP,
    S_AVG_DONE, S_RING_WR, S_TILT0, S_TILT_DIV, S_TILT1, S_TILT_END, S_FINISH, S_DIV_WAIT
  } state_t;

  function automatic logic [19:0] mag20(input logic signed [19:0] x);
    return x[19] ? 20'(-x) : 20'(x);
  endfunction

  // configuration
  logic [4:0] average_length;
  logic       average_enable;
  logic       failsafe_enable;
  logic [1:0] tilt_mode;

  // filter state
  logic signed [13:0] zero_offset [3];
  logic signed [23:0] cal_sum [3];
  logic signed [15:0] prev_out [3];
  logic signed [19:0] avg_sum [3];
  logic [POS_W-1:0]   pos;
  logic [9:0]         calibration_count;

  // working registers
  state_t             state;
  state_t             resume;
  logic [1:0]         axis;
  logic signed [13:0] raw_r [3];
  logic signed [15:0] val [3];
  logic signed [15:0] tilt_tmp;
  logic [2:0][15:0]   clamp_row;
  logic               cal_now;
  logic               done_flag;
  logic               tilt_flag;
  logic               restart_flag;
  logic               div_neg;
  logic               chk_zero;
  logic [19:0]        tilt_mag;
  logic [15:0]        tilt_q;

  // divider interface
  logic                div_start;
  logic [DIV_N-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  div_stat_t           div_stat;
  logic [DIV_N-1:0]    div_quo;
  logic [DVS_W-1:0]    div_rem;

  // ring memory
  logic [2:0][15:0]           ring_mem [AVERAGE_DEPTH];
  logic [AVERAGE_DEPTH-1:0]   ring_valid;
  logic [2:0][15:0]           ring_rd;
  logic                       ring_rd_valid;
  logic                       ring_we;

  // combinational helpers
  logic               in_accept;
  logic [9:0]         count_in;
  logic [LEN_W-1:0]   len_eff;
  logic [17:0]        chk_prod;
  logic [9:0]         chk_back;
  logic               cal_first;
  logic signed [23:0] base_sum;
  logic signed [15:0] base_prev;
  logic signed [16:0] motion_d;
  logic               jump;
  logic signed [23:0] sum_next;
  logic signed [16:0] rv;
  logic signed [16:0] pv;
  logic signed [16:0] lo;
  logic signed [16:0] hi;
  logic signed [16:0] clamped;
  logic signed [15:0] c16;
  logic signed [15:0] ring_entry;
  logic signed [21:0] avg_wide;
  logic signed [19:0] avg_next;
  logic [DIV_N-1:0]   q_signed;
  logic signed [15:0] q16;
  logic               tilt_left;
  logic signed [16:0] tilt_x;
  logic signed [19:0] tilt_prod;
  logic [39:0]        tilt_full;
  logic signed [15:0] tq16;
  logic               out_free;

  gzc_div #(.DVS_W(DVS_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign ring_we   = (state == S_RING_WR);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    count_in = begin_calibration ? CAL_LOAD : calibration_count;

    if (average_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(average_length) > 32'(AVERAGE_DEPTH)) begin
      len_eff = LEN_W'(AVERAGE_DEPTH);
    end else begin
      len_eff = LEN_W'(average_length);
    end

    // tenth count check
    chk_prod = 18'(calibration_count) * 18'(CHECK_RECIP);
    chk_back = 10'(chk_prod[17:CHECK_RECIP_SHIFT]) * CHECK_PERIOD;

    // calibration step for one axis
    cal_first = (calibration_count == CAL_LOAD);
    base_sum  = cal_first ? '0 : cal_sum[axis];
    base_prev = (cal_first && failsafe_enable) ? 16'(raw_r[axis]) : prev_out[axis];
    motion_d  = 17'(raw_r[axis]) - 17'(base_prev);
    jump      = (motion_d > MOTION_LIMIT) || (motion_d < -MOTION_LIMIT);
    sum_next  = base_sum + 24'(raw_r[axis]);

    // offset removal and glitch clamp
    rv = 17'(raw_r[axis]) - 17'(zero_offset[axis]);
    pv = 17'(prev_out[axis]);
    lo = pv - GLITCH_LIMIT;
    hi = pv + GLITCH_LIMIT;
    if (rv < lo) begin
      clamped = lo;
    end else if (rv > hi) begin
      clamped = hi;
    end else begin
      clamped = rv;
    end
    c16 = clamped[15:0];

    // moving average
    ring_entry = ring_rd_valid ? signed'(ring_rd[axis]) : '0;
    avg_wide   = 22'(avg_sum[axis]) - 22'(ring_entry) + 22'(c16);
    avg_next   = avg_wide[19:0];

    q_signed = div_neg ? DIV_N'(-div_quo) : div_quo;
    q16      = signed'(q_signed[15:0]);

    // rotation operand
    tilt_left = (tilt_mode == TILT_LEFT);
    if (state == S_TILT0) begin
      tilt_x = tilt_left ? (17'(val[0]) + 17'(val[1])) : (17'(val[0]) - 17'(val[1]));
    end else begin
      tilt_x = tilt_left ? (17'(val[1]) - 17'(val[0])) : (17'(val[1]) + 17'(val[0]));
    end
    tilt_prod = 20'(tilt_x) * TILT_NUM;
    tilt_full = 40'(tilt_mag) * 40'(TILT_RECIP);
    tq16      = div_neg ? -signed'(tilt_q) : signed'(tilt_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_length  <= 5'd10;
      average_enable  <= 1'b1;
      failsafe_enable <= 1'b0;
      tilt_mode       <= TILT_NONE;
    end else if (wr_en) begin
      case (wr_index)
        REG_AVERAGE_LENGTH:  average_length  <= wr_data;
        REG_AVERAGE_ENABLE:  average_enable  <= wr_data[0];
        REG_FAILSAFE_ENABLE: failsafe_enable <= wr_data[0];
        REG_TILT_MODE:       tilt_mode       <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[pos] <= clamp_row;
    end
    ring_rd <= ring_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid    <= '0;
      ring_rd_valid <= 1'b0;
    end else begin
      if (ring_we) begin
        ring_valid[pos] <= 1'b1;
      end
      ring_rd_valid <= ring_valid[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      resume            <= S_IDLE;
      axis              <= '0;
      out_valid         <= 1'b0;
      div_start         <= 1'b0;
      calibration_count <= '0;
      pos               <= '0;
      for (int a = 0; a < 3; a++) begin
        zero_offset[a] <= '0;
        cal_sum[a]     <= '0;
        prev_out[a]    <= '0;
        avg_sum[a]     <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            raw_r[0]          <= raw_x;
            raw_r[1]          <= raw_y;
            raw_r[2]          <= raw_z;
            calibration_count <= count_in;
            cal_now           <= (count_in != '0);
            done_flag         <= (count_in == CAL_LAST);
            tilt_flag         <= 1'b0;
            restart_flag      <= 1'b0;
            axis              <= '0;
            if (count_in != '0) begin
              state <= S_CAL_CHK;
            end else begin
              state <= S_POS;
            end
          end
        end

        S_CAL_CHK: begin
          chk_zero <= (chk_back == calibration_count);
          state    <= S_CAL_AXIS;
        end

        S_CAL_AXIS: begin
          if (failsafe_enable && chk_zero) begin
            if (jump) begin
              tilt_flag <= 1'b1;
            end
            prev_out[axis] <= 16'(raw_r[axis]);
          end else begin
            prev_out[axis] <= base_prev;
          end
          cal_sum[axis]     <= sum_next;
          zero_offset[axis] <= sum_next[OFFSET_SHIFT+13:OFFSET_SHIFT];
          if (axis == 2'd2) begin
            axis  <= '0;
            state <= S_CAL_END;
          end else begin
            axis <= axis + 2'd1;
          end
        end

        S_CAL_END: begin
          if (failsafe_enable) begin
            calibration_count <= tilt_flag ? CAL_RESTART : calibration_count - 10'd1;
            restart_flag      <= tilt_flag;
            for (int a = 0; a < 3; a++) begin
              val[a] <= 16'(raw_r[a]);
            end
            state <= S_FINISH;
          end else begin
            calibration_count <= calibration_count - 10'd1;
            state             <= S_POS;
          end
        end

        S_POS: begin
          axis <= '0;
          if (average_enable) begin
            div_start    <= 1'b1;
            div_dividend <= DIV_N'(LEN_W'(pos) + LEN_W'(1));
            div_divisor  <= DVS_W'(len_eff);
            resume       <= S_RD_POS;
            state        <= S_DIV_WAIT;
          end else begin
            state <= S_CLAMP;
          end
        end

        S_RD_POS: begin
          pos   <= div_rem[POS_W-1:0];
          state <= S_RD_WAIT;
        end

        S_RD_WAIT: begin
          state <= S_CLAMP;
        end

        S_CLAMP: begin
          clamp_row[axis] <= c16;
          if (average_enable) begin
            avg_sum[axis] <= avg_next;
            div_neg       <= avg_next[19];
            div_start     <= 1'b1;
            div_dividend  <= mag20(avg_next);
            div_divisor   <= DVS_W'(len_eff);
            resume        <= S_AVG_DONE;
            state         <= S_DIV_WAIT;
          end else begin
            prev_out[axis] <= c16;
            val[axis]      <= c16;
            if (axis == 2'd2) begin
              axis  <= '0;
              state <= S_TILT0;
            end else begin
              axis <= axis + 2'd1;
            end
          end
        end

        S_AVG_DONE: begin
          prev_out[axis] <= q16;
          val[axis]      <= q16;
          if (axis == 2'd2) begin
            axis  <= '0;
            state <= S_RING_WR;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_CLAMP;
          end
        end

        S_RING_WR: begin
          state <= S_TILT0;
        end

        S_TILT0: begin
          if (tilt_mode == TILT_LEFT || tilt_mode == TILT_RIGHT) begin
            div_neg  <= tilt_prod[19];
            tilt_mag <= mag20(tilt_prod);
            resume   <= S_TILT1;
            state    <= S_TILT_DIV;
          end else begin
            state <= S_FINISH;
          end
        end

        S_TILT_DIV: begin
          tilt_q <= tilt_full[TILT_RECIP_SHIFT+15:TILT_RECIP_SHIFT];
          state  <= resume;
        end

        S_TILT1: begin
          tilt_tmp <= tq16;
          div_neg  <= tilt_prod[19];
          tilt_mag <= mag20(tilt_prod);
          resume   <= S_TILT_END;
          state    <= S_TILT_DIV;
        end

        S_TILT_END: begin
          val[0] <= tilt_tmp;
          val[1] <= tq16;
          state  <= S_FINISH;
        end

        S_FINISH: begin
          if (out_free) begin
            rate_x           <= val[0];
            rate_y           <= val[1];
            rate_z           <= val[2];
            calibrating      <= cal_now;
            calibration_done <= done_flag;
            motion_restart   <= restart_flag;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end

        S_DIV_WAIT: begin
          div_start <= 1'b0;
          if (div_stat.done) begin
            state <= resume;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/gyro_zero_calibrate_filter_tb.sv]
// self-checking testbench for the gyro zero calibration filter
module gyro_zero_calibrate_filter_tb;
  import gzc_pkg::*;

  localparam int AVERAGE_DEPTH = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 4000;
  localparam int TAIL_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam int RAW_MAX = 8191;
  localparam int RAW_MIN = -8192;
  localparam logic [1:0] TILT_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        cal;
    logic        done;
    logic        restart;
  } rate_t;

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [1:0]         wr_index;
  logic [4:0]         wr_data;
  logic               in_valid;
  logic               in_stall;
  logic               begin_calibration;
  logic signed [13:0] raw_x;
  logic signed [13:0] raw_y;
  logic signed [13:0] raw_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic               calibrating;
  logic               calibration_done;
  logic               motion_restart;

  gyro_zero_calibrate_filter #(.AVERAGE_DEPTH(AVERAGE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .begin_calibration(begin_calibration),
    .raw_x(raw_x),
    .raw_y(raw_y),
    .raw_z(raw_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rate_x(rate_x),
    .rate_y(rate_y),
    .rate_z(rate_z),
    .calibrating(calibrating),
    .calibration_done(calibration_done),
    .motion_restart(motion_restart)
  );

  // filter state as the block should hold it
  logic [4:0]         cfg_len;
  logic               cfg_avg;
  logic               cfg_fs;
  logic [1:0]         cfg_tilt;
  logic signed [13:0] zero_off [3];
  logic signed [23:0] cal_sum [3];
  logic signed [15:0] prev_rate [3];
  logic signed [15:0] avg_ring [3][AVERAGE_DEPTH];
  logic signed [19:0] avg_sum [3];
  int unsigned        ring_pos;
  logic [9:0]         cal_count;

  rate_t expected_rates[$];

  int items_in;
  int results_seen;
  int errors;
  int cal_done_seen;
  int restarts_seen;
  int stuck;
  int src_idle;
  int sink_stall;
  bit hold_off;
  int hold_left;

  function automatic void clear_model();
    int a, i;
    cfg_len = 5'd10;
    cfg_avg = 1'b1;
    cfg_fs = 1'b0;
    cfg_tilt = TILT_NONE;
    for (a = 0; a < 3; a++) begin
      zero_off[a] = '0;
      cal_sum[a] = '0;
      prev_rate[a] = '0;
      avg_sum[a] = '0;
      for (i = 0; i < AVERAGE_DEPTH; i++) avg_ring[a][i] = '0;
    end
    ring_pos = 0;
    cal_count = '0;
  endfunction

  function automatic int wrap16(input int v);
    logic signed [15:0] w;
    w = v[15:0];
    return w;
  endfunction

  function automatic int tilt_scale(input int v);
    return wrap16((v * int'(TILT_NUM)) / int'(TILT_DEN));
  endfunction

  function automatic rate_t condition_sample(input logic b, input logic signed [13:0] rx,
                                             input logic signed [13:0] ry,
                                             input logic signed [13:0] rz);
    int raw [3];
    int val [3];
    int a, d, v, p, s, t, len;
    bit motion;
    rate_t r;
    raw[0] = rx;
    raw[1] = ry;
    raw[2] = rz;
    r = '0;
    motion = 1'b0;
    if (b) cal_count = CAL_LOAD;
    if (cal_count != 0) begin
      r.cal = 1'b1;
      r.done = (cal_count == CAL_LAST);
      for (a = 0; a < 3; a++) begin
        if (cal_count == CAL_LOAD) begin
          cal_sum[a] = '0;
          if (cfg_fs) prev_rate[a] = raw[a][15:0];
        end
        if (cfg_fs && cal_count % CHECK_PERIOD == 0) begin
          d = raw[a] - int'(prev_rate[a]);
          if (d > MOTION_LIMIT || d < -MOTION_LIMIT) motion = 1'b1;
          prev_rate[a] = raw[a][15:0];
        end
        cal_sum[a] = cal_sum[a] + raw[a];
        t = int'(cal_sum[a]) >>> OFFSET_SHIFT;
        zero_off[a] = t[13:0];
      end
      if (cfg_fs) begin
        if (motion) begin
          cal_count = CAL_RESTART;
          r.restart = 1'b1;
        end else begin
          cal_count = cal_count - 1;
        end
        r.x = raw[0][15:0];
        r.y = raw[1][15:0];
        r.z = raw[2][15:0];
        return r;
      end
      cal_count = cal_count - 1;
    end
    len = cfg_len;
    if (len == 0) len = 1;
    if (len > AVERAGE_DEPTH) len = AVERAGE_DEPTH;
    if (cfg_avg) ring_pos = (ring_pos + 1) % len;
    for (a = 0; a < 3; a++) begin
      v = raw[a] - int'(zero_off[a]);
      p = prev_rate[a];
      if (v < p - GLITCH_LIMIT) v = p - GLITCH_LIMIT;
      if (v > p + GLITCH_LIMIT) v = p + GLITCH_LIMIT;
      if (cfg_avg) begin
        s = int'(avg_sum[a]) - int'(avg_ring[a][ring_pos]);
        avg_ring[a][ring_pos] = v[15:0];
        s = s + v;
        avg_sum[a] = s[19:0];
        v = wrap16(int'(avg_sum[a]) / len);
      end
      prev_rate[a] = v[15:0];
      val[a] = v;
    end
    case (cfg_tilt)
      TILT_LEFT: begin
        t = tilt_scale(val[1] - val[0]);
        val[0] = tilt_scale(val[0] + val[1]);
        val[1] = t;
      end
      TILT_RIGHT: begin
        t = tilt_scale(val[1] + val[0]);
        val[0] = tilt_scale(val[0] - val[1]);
        val[1] = t;
      end
      default: ;
    endcase
    r.x = val[0][15:0];
    r.y = val[1][15:0];
    r.z = val[2][15:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // prediction on accepted input items, comparison on accepted result items
  always @(posedge clk) begin : monitor
    rate_t got;
    rate_t want;
    if (rst) begin
      clear_model();
    end else begin
      if (out_valid && !out_stall) begin
        got = {rate_x, rate_y, rate_z, calibrating, calibration_done, motion_restart};
        results_seen++;
        if (got.done) cal_done_seen++;
        if (got.restart) restarts_seen++;
        if (expected_rates.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result item: rate %0d %0d %0d flags %b%b%b",
                     $signed(got.x), $signed(got.y), $signed(got.z),
                     got.cal, got.done, got.restart);
        end else begin
          want = expected_rates.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch on result %0d: rate %0d %0d %0d flags %b%b%b, %s %0d %0d %0d flags %b%b%b",
                       results_seen, $signed(got.x), $signed(got.y), $signed(got.z),
                       got.cal, got.done, got.restart, "expected",
                       $signed(want.x), $signed(want.y), $signed(want.z),
                       want.cal, want.done, want.restart);
          end
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_AVERAGE_LENGTH:  cfg_len = wr_data;
          REG_AVERAGE_ENABLE:  cfg_avg = wr_data[0];
          REG_FAILSAFE_ENABLE: cfg_fs = wr_data[0];
          REG_TILT_MODE:       cfg_tilt = wr_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_rates.push_back(condition_sample(begin_calibration, raw_x, raw_y, raw_z));
        items_in++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
    else stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("no item moved in %0d cycles", STUCK_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall, or a long hold when asked
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_off) begin
        hold_left = HOLD_CYCLES;
        hold_off = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall);
      end
    end
  end

  function automatic int jitter(input int bias);
    return bias + int'($urandom_range(8)) - 4;
  endfunction

  function automatic int rand_raw();
    return int'($urandom_range(16383)) + RAW_MIN;
  endfunction

  function automatic int rand_bias();
    return int'($urandom_range(16000)) - 8000;
  endfunction

  task automatic set_idle(input int src, input int sink);
    src_idle = src;
    sink_stall = sink;
  endtask

  task automatic send_sample(input logic b, input int x, input int y, input int z);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    begin_calibration <= b;
    raw_x <= x[13:0];
    raw_y <= y[13:0];
    raw_z <= z[13:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_steady(input int n, input int bx, input int by, input int bz);
    repeat (n) send_sample(1'b0, jitter(bx), jitter(by), jitter(bz));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_filter(input logic [4:0] len, input logic avg, input logic fs,
                            input logic [1:0] tilt);
    drain();
    wr_en <= 1'b1;
    wr_index <= REG_AVERAGE_LENGTH;
    wr_data <= len;
    @(negedge clk);
    wr_index <= REG_AVERAGE_ENABLE;
    wr_data <= 5'(avg);
    @(negedge clk);
    wr_index <= REG_FAILSAFE_ENABLE;
    wr_data <= 5'(fs);
    @(negedge clk);
    wr_index <= REG_TILT_MODE;
    wr_data <= 5'(tilt);
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_extremes();
    set_idle(0, 0);
    send_sample(1'b0, RAW_MAX, RAW_MIN, 0);
    send_sample(1'b0, RAW_MAX, RAW_MIN, 0);
    send_sample(1'b0, RAW_MIN, RAW_MAX, -1);
    send_sample(1'b0, 0, 0, 0);
    send_sample(1'b1, RAW_MIN, RAW_MIN, RAW_MAX);
    send_sample(1'b0, RAW_MAX, RAW_MAX, RAW_MIN);
  endtask

  task automatic test_window_and_tilt();
    // zero window, oversized window, unused tilt code, bypassed average
    set_filter(5'd0, 1'b1, 1'b0, TILT_LEFT);
    send_sample(1'b0, RAW_MAX, RAW_MAX, RAW_MIN);
    send_sample(1'b0, RAW_MIN, 1234, -4321);
    set_filter(5'd31, 1'b1, 1'b0, TILT_RIGHT);
    send_sample(1'b0, RAW_MAX, RAW_MIN, RAW_MIN);
    send_sample(1'b0, -777, RAW_MAX, 4321);
    set_filter(5'd1, 1'b1, 1'b0, TILT_UNUSED);
    send_sample(1'b0, RAW_MIN, RAW_MIN, RAW_MAX);
    send_sample(1'b0, 55, -55, 0);
    set_filter(5'd16, 1'b0, 1'b0, TILT_NONE);
    send_sample(1'b0, RAW_MAX, RAW_MAX, RAW_MAX);
    send_sample(1'b0, RAW_MIN, RAW_MIN, RAW_MIN);
  endtask

  task automatic test_failsafe_restart();
    set_filter(5'd10, 1'b1, 1'b1, TILT_NONE);
    send_sample(1'b1, 100, 200, -300);
    send_sample(1'b0, 101, 199, -300);
    send_sample(1'b0, 130, 200, -300);
    send_sample(1'b0, 100, 200, -300);
    send_sample(1'b0, 100, 200, -300);
    send_sample(1'b0, RAW_MAX, RAW_MIN, RAW_MAX);
  endtask

  task automatic test_normal_calibration();
    int bx, by, bz;
    bx = rand_bias();
    by = rand_bias();
    bz = rand_bias();
    set_filter(5'd10, 1'b1, 1'b0, TILT_NONE);
    set_idle(17, 17);
    send_sample(1'b1, jitter(bx), jitter(by), jitter(bz));
    send_steady(515, bx, by, bz);
    repeat (60) send_sample(1'b0, rand_raw(), rand_raw(), rand_raw());
  endtask

  task automatic test_failsafe_calibration();
    int bx, by, bz;
    bx = rand_bias();
    by = rand_bias();
    bz = rand_bias();
    set_filter(5'd16, 1'b1, 1'b1, TILT_LEFT);
    set_idle(85, 0);
    send_sample(1'b1, jitter(bx), jitter(by), jitter(bz));
    send_steady(40, bx, by, bz);
    // a step on one axis long enough to reach a tenth count
    send_steady(12, bx + 50, by, bz);
    send_steady(20, bx, by, bz);
    send_sample(1'b1, jitter(bx), jitter(by), jitter(bz));
    send_steady(515, bx, by, bz);
    send_steady(30, bx, by, bz);
  endtask

  task automatic test_backpressure();
    set_idle(0, 0);
    hold_off = 1'b1;
    repeat (12) send_sample(1'b0, rand_raw(), rand_raw(), rand_raw());
    drain();
  endtask

  task automatic test_random_mix();
    int bx, by, bz, phase;
    for (phase = 0; phase < 8; phase++) begin
      set_filter(5'($urandom_range(31)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 2'($urandom_range(3)));
      case (phase % 4)
        0: set_idle(0, 0);
        1: set_idle(85, 0);
        2: set_idle(0, 85);
        default: set_idle(17, 17);
      endcase
      bx = rand_bias();
      by = rand_bias();
      bz = rand_bias();
      repeat (80) begin
        if ($urandom_range(7) == 0)
          send_sample($urandom_range(39) == 0, rand_raw(), rand_raw(), rand_raw());
        else
          send_sample($urandom_range(39) == 0, jitter(bx), jitter(by), jitter(bz));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_AVERAGE_LENGTH;
    wr_data = '0;
    in_valid = 1'b0;
    begin_calibration = 1'b0;
    raw_x = '0;
    raw_y = '0;
    raw_z = '0;
    src_idle = 0;
    sink_stall = 0;
    hold_off = 1'b0;
    items_in = 0;
    results_seen = 0;
    errors = 0;
    cal_done_seen = 0;
    restarts_seen = 0;
    stuck = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_window_and_tilt();
    test_failsafe_restart();
    test_normal_calibration();
    test_failsafe_calibration();
    test_backpressure();
    test_random_mix();

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    errors += expected_rates.size();
    $display("%0d items through extremes, window and tilt settings, normal and failsafe",
             items_in);
    $display("calibration, backpressure and random mixes; %0d calibrations done, %0d restarts",
             cal_done_seen, restarts_seen);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
